[rtl/fxt1_pkg.sv]
// Package with shared types, mode codes and helper functions of the block decoder.
package fxt1_pkg;

  typedef struct packed {
    logic [31:0] block_word3;
    logic [31:0] block_word2;
    logic [31:0] block_word1;
    logic [31:0] block_word0;
  } fxt1_in_t;

  typedef struct packed {
    logic [1:0]  texel_row;
    logic [2:0]  texel_column;
    logic [31:0] texel_abgr;
    logic        last_texel;
  } fxt1_out_t;

  typedef enum logic [1:0] {
    MODE_MIXED  = 2'd0,
    MODE_HIGH   = 2'd1,
    MODE_CHROMA = 2'd2,
    MODE_ALPHA  = 2'd3
  } fxt1_mode_t;

  // A classified block as it waits in the queue.
  typedef struct packed {
    fxt1_mode_t  mode;
    logic        flag;
    logic [127:0] bits;
  } fxt1_job_t;

  localparam int QueueDepth = 2;

  // Expand a 5-bit color field to 8 bits.
  function automatic logic [7:0] expand5(input logic [4:0] v);
    expand5 = {v, v[4:2]};
  endfunction

  // Read 5 bits of the block starting at pos; bits past 127 read as zero.
  function automatic logic [4:0] field5(input logic [127:0] b, input logic [7:0] pos);
    logic [132:0] ext;
    ext = {5'd0, b};
    field5 = ext[pos +: 5];
  endfunction

endpackage

[rtl/fxt1_front.sv]
// Front end: takes a block, classifies its mode and pushes it into a small queue.
module fxt1_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fxt1_pkg::fxt1_in_t in_block,
  output logic              job_valid,
  output fxt1_pkg::fxt1_job_t job,
  input  logic              job_pop
);
  import fxt1_pkg::*;

  fxt1_job_t q_r [QueueDepth];
  logic      wp_r, rp_r;
  logic      wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  fxt1_job_t in_job;
  logic      push;

  always_comb begin
    in_job.bits = {in_block.block_word3, in_block.block_word2,
                   in_block.block_word1, in_block.block_word0};
    in_job.flag = in_block.block_word3[28];
    if (in_block.block_word3[31]) begin
      in_job.mode = MODE_MIXED;
    end else if (!in_block.block_word3[30]) begin
      in_job.mode = MODE_HIGH;
    end else if (!in_block.block_word3[29]) begin
      in_job.mode = MODE_CHROMA;
    end else begin
      in_job.mode = MODE_ALPHA;
    end
  end

  assign busy      = (cnt_r == 2'(QueueDepth));
  assign push      = start && !busy;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = job_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(job_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_job;
    end
  end

endmodule

[rtl/fxt1_back.sv]
// Back end: builds the palette of a block and emits its 32 texels, one per cycle.
module fxt1_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  fxt1_pkg::fxt1_job_t job,
  output logic               job_pop,
  output logic               out_valid,
  output fxt1_pkg::fxt1_out_t out_texel
);
  import fxt1_pkg::*;

  // Palette stage registers: two halves of eight entries.
  logic [31:0] pal_r [2][8];
  logic [31:0] pal_nxt [2][8];
  logic        active_r, active_nxt;
  fxt1_mode_t  mode_r;
  logic [95:0] idx_r;
  logic [4:0]  pos_r, pos_nxt;
  logic        load;
  logic        ov_r;

  // Palette build is combinational and registered on load; divisions by 2, 3 and 6 are by constants.
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = v * 10'd683;
    div3 = p[18:11];
  endfunction
  function automatic logic [7:0] div6(input logic [11:0] v);
    logic [23:0] p;
    p = v * 12'd2731;
    div6 = p[21:14];
  endfunction
  function automatic logic [31:0] pack(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic [7:0] a);
    pack = {a, b, g, r};
  endfunction

  always_comb begin
    logic [7:0] ea [3];
    logic [7:0] eb [3];
    logic [7:0] p1 [3];
    logic [7:0] p2 [3];
    logic [7:0] cl [3][4];
    logic [7:0] v [4];
    logic [7:0] base;
    logic [7:0] s;
    for (int h = 0; h < 2; h++) begin
      for (int i = 0; i < 8; i++) begin
        pal_nxt[h][i] = 32'd0;
      end
    end
    case (job.mode)
      MODE_MIXED: begin
        for (int h = 0; h < 2; h++) begin
          base = (h == 1) ? 8'h5E : 8'h40;
          for (int c = 0; c < 3; c++) begin
            ea[c] = expand5(field5(job.bits, base + 8'(5 * c)));
            eb[c] = expand5(field5(job.bits, base + 8'(15 + 5 * c)));
            if (job.flag) begin
              p1[c] = 8'((9'(ea[c]) + 9'(eb[c])) >> 1);
              p2[c] = ea[c];
            end else begin
              p1[c] = div3(10'(ea[c]) + 10'({eb[c], 1'b0}) + 10'd1);
              p2[c] = div3(10'({ea[c], 1'b0}) + 10'(eb[c]) + 10'd1);
            end
          end
          pal_nxt[h][0] = pack(eb[0], eb[1], eb[2], 8'hFF);
          pal_nxt[h][1] = pack(p1[0], p1[1], p1[2], 8'hFF);
          pal_nxt[h][2] = pack(p2[0], p2[1], p2[2], 8'hFF);
          pal_nxt[h][3] = job.flag ? 32'd0 : pack(ea[0], ea[1], ea[2], 8'hFF);
        end
      end
      MODE_HIGH: begin
        for (int c = 0; c < 3; c++) begin
          ea[c] = expand5(field5(job.bits, 8'(96 + 5 * c)));
          eb[c] = expand5(field5(job.bits, 8'(111 + 5 * c)));
        end
        for (int i = 0; i < 7; i++) begin
          for (int c = 0; c < 3; c++) begin
            v[c] = div6(12'(ea[c]) * 12'(6 - i) + 12'(eb[c]) * 12'(i) + 12'd2);
          end
          pal_nxt[0][i] = pack(v[0], v[1], v[2], 8'hFF);
          pal_nxt[1][i] = pal_nxt[0][i];
        end
      end
      MODE_CHROMA: begin
        for (int i = 0; i < 4; i++) begin
          pal_nxt[0][i] = pack(expand5(field5(job.bits, 8'(64 + 15 * i))),
                               expand5(field5(job.bits, 8'(69 + 15 * i))),
                               expand5(field5(job.bits, 8'(74 + 15 * i))), 8'hFF);
          pal_nxt[1][i] = pal_nxt[0][i];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          for (int c = 0; c < 3; c++) begin
            cl[i][c] = expand5(field5(job.bits, 8'(64 + 15 * i + 5 * c)));
          end
          cl[i][3] = expand5(field5(job.bits, 8'(109 + 5 * i)));
        end
        if (job.flag) begin
          for (int h = 0; h < 2; h++) begin
            s = (h == 1) ? 8'd2 : 8'd0;
            for (int i = 0; i < 4; i++) begin
              for (int c = 0; c < 4; c++) begin
                v[c] = div3(10'(cl[s[1:0]][c]) * 10'(3 - i) + 10'(cl[1][c]) * 10'(i)
                            + 10'd1);
              end
              pal_nxt[h][i] = pack(v[0], v[1], v[2], v[3]);
            end
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            pal_nxt[0][i] = pack(cl[i][0], cl[i][1], cl[i][2], cl[i][3]);
            pal_nxt[1][i] = pal_nxt[0][i];
          end
        end
      end
    endcase
  end

  // A new block loads when the back end is idle or the last texel of the current one goes out.
  assign load    = job_valid && (!active_r || pos_r == 5'd31);
  assign job_pop = load;

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    if (load) begin
      active_nxt = 1'b1;
      pos_nxt    = 5'd0;
    end else if (active_r) begin
      pos_nxt = pos_r + 5'd1;
      if (pos_r == 5'd31) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= 5'd0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      ov_r     <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pal_r  <= pal_nxt;
      mode_r <= job.mode;
      idx_r  <= job.bits[95:0];
    end
  end

  // Texel index lookup from the held block bits.
  always_comb begin
    logic       half;
    logic [1:0] cc;
    logic [1:0] row;
    logic [6:0] p;
    logic [2:0] idx;
    row  = pos_r[4:3];
    half = pos_r[2];
    cc   = pos_r[1:0];
    if (mode_r == MODE_HIGH) begin
      p   = 7'(48 * half) + 7'(3 * ({row, 2'b00} + 4'(cc)));
      idx = idx_r[p +: 3];
    end else begin
      p   = {half, 5'd0} + {row, 3'b000} + {4'd0, cc, 1'b0};
      idx = {1'b0, idx_r[p +: 2]};
    end
    out_texel.texel_row    = row;
    out_texel.texel_column = pos_r[2:0];
    out_texel.texel_abgr   = pal_r[half][idx];
    out_texel.last_texel   = (pos_r == 5'd31);
  end

  assign out_valid = ov_r;

endmodule

[rtl/fxt1_block_decoder.sv]
// Top level of the compressed texel block decoder.
// The block takes one 128-bit block when start is high and busy is low, and emits its
// 32 texels in raster order, one per cycle, each marked by out_valid for exactly one
// cycle; the receiver cannot stall. Blocks follow back to back with no gap when the next
// one is already queued. The front end holds up to two waiting blocks in a queue, so busy
// rises only when two blocks are queued behind the one being emitted. A block passes
// through the queue, the back end's palette and position registers and the output
// register before its first texel is on the outputs.
module fxt1_block_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fxt1_pkg::fxt1_in_t  in_block,
  output logic                out_valid,
  output fxt1_pkg::fxt1_out_t out_texel
);
  import fxt1_pkg::*;

  logic      job_valid, job_pop;
  fxt1_job_t job;
  fxt1_out_t texel_raw;
  logic      texel_valid;
  fxt1_out_t out_r;

  fxt1_front u_front (
    .clk, .rst_n, .start, .busy, .in_block,
    .job_valid, .job, .job_pop
  );

  fxt1_back u_back (
    .clk, .rst_n, .job_valid, .job, .job_pop,
    .out_valid(texel_valid), .out_texel(texel_raw)
  );

  // The back end registers its valid once more than its texel; the texel is registered here to match.
  always_ff @(posedge clk) begin
    out_r <= texel_raw;
  end

  assign out_valid = texel_valid;
  assign out_texel = out_r;

endmodule

[rtl/fxt1_checker.sv]
// Port-level checker for the block decoder and its bind statement.
module fxt1_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input fxt1_pkg::fxt1_out_t out_texel
);
  import fxt1_pkg::*;

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_texel.last_texel ==
                   (out_texel.texel_row == 2'd3 && out_texel.texel_column == 3'd7)))
    else $error("last flag does not match texel position");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_texel.last_texel |=> out_valid)
    else $error("texels of a block are not contiguous");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_texel.last_texel |=>
      ({out_texel.texel_row, out_texel.texel_column} ==
       $past({out_texel.texel_row, out_texel.texel_column}) + 5'd1))
    else $error("texel positions out of order");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_texel.texel_row == 2'd0 && out_texel.texel_column == 3'd0))
    else $error("block does not start at row zero column zero");

endmodule

bind fxt1_block_decoder fxt1_checker u_checker (
  .clk, .rst_n, .out_valid, .out_texel
);

[verif/fxt1_block_decoder_tb.sv]
// Self-checking testbench of the compressed texel block decoder.
`timescale 1ns / 100ps

module fxt1_block_decoder_tb;
  import fxt1_pkg::*;

  // Queue of decoded texels that the block owes, oldest first.
  class texel_scoreboard;
    fxt1_out_t owed_texels[$];
    int        mismatches;
    int        blocks_noted;
    int        texels_checked;
    logic [127:0] blk;

    function automatic logic bit_at(int pos);
      if (pos >= 128) return 1'b0;
      return blk[pos];
    endfunction

    function automatic logic [7:0] color5(int pos);
      logic [4:0] v;
      for (int b = 0; b < 5; b++) v[b] = bit_at(pos + b);
      return {v, v[4:2]};
    endfunction

    function automatic logic [31:0] abgr(int r, int g, int b, int a);
      return {a[7:0], b[7:0], g[7:0], r[7:0]};
    endfunction

    // Works out the whole palette and then the 32 texels of one block.
    function void note_block(fxt1_in_t blk_in);
      logic [31:0] pal[2][8];
      int ea[3], eb[3], pv[4][3], v[4], cols[3][4];
      logic flag, high_mode;
      int base, idx, pos, half, s;
      fxt1_out_t t;
      blk = {blk_in.block_word3, blk_in.block_word2, blk_in.block_word1,
             blk_in.block_word0};
      flag = blk[124];
      high_mode = 1'b0;
      for (int h = 0; h < 2; h++) for (int i = 0; i < 8; i++) pal[h][i] = '0;
      if (blk[127]) begin
        for (int h = 0; h < 2; h++) begin
          base = h ? 'h5E : 'h40;
          for (int c = 0; c < 3; c++) begin
            ea[c] = color5(base + 5 * c);
            eb[c] = color5(base + 15 + 5 * c);
            pv[0][c] = eb[c];
            if (flag) begin
              pv[1][c] = (ea[c] + eb[c]) / 2;
              pv[2][c] = ea[c];
              pv[3][c] = 0;
            end else begin
              pv[1][c] = (ea[c] + 2 * eb[c] + 1) / 3;
              pv[2][c] = (2 * ea[c] + eb[c] + 1) / 3;
              pv[3][c] = ea[c];
            end
          end
          for (int i = 0; i < 4; i++)
            pal[h][i] = (flag && i == 3) ? '0 : abgr(pv[i][0], pv[i][1], pv[i][2], 255);
        end
      end else if (!blk[126]) begin
        high_mode = 1'b1;
        for (int c = 0; c < 3; c++) begin
          ea[c] = color5(96 + 5 * c);
          eb[c] = color5(111 + 5 * c);
        end
        for (int i = 0; i < 7; i++) begin
          for (int c = 0; c < 3; c++) v[c] = (ea[c] * (6 - i) + eb[c] * i + 2) / 6;
          pal[0][i] = abgr(v[0], v[1], v[2], 255);
        end
        pal[1] = pal[0];
      end else if (!blk[125]) begin
        for (int i = 0; i < 4; i++) begin
          base = 64 + 15 * i;
          pal[0][i] = abgr(color5(base), color5(base + 5), color5(base + 10), 255);
        end
        pal[1] = pal[0];
      end else begin
        for (int i = 0; i < 3; i++) begin
          for (int c = 0; c < 3; c++) cols[i][c] = color5(64 + 15 * i + 5 * c);
          cols[i][3] = color5(109 + 5 * i);
        end
        if (flag) begin
          for (int h = 0; h < 2; h++) begin
            s = h ? 2 : 0;
            for (int i = 0; i < 4; i++) begin
              for (int c = 0; c < 4; c++)
                v[c] = (cols[s][c] * (3 - i) + cols[1][c] * i + 1) / 3;
              pal[h][i] = abgr(v[0], v[1], v[2], v[3]);
            end
          end
        end else begin
          for (int i = 0; i < 3; i++)
            pal[0][i] = abgr(cols[i][0], cols[i][1], cols[i][2], cols[i][3]);
          pal[1] = pal[0];
        end
      end
      for (int row = 0; row < 4; row++) begin
        for (int col = 0; col < 8; col++) begin
          half = col >> 2;
          if (high_mode) begin
            pos = 48 * half + 3 * (4 * row + (col & 3));
            idx = bit_at(pos) | (bit_at(pos + 1) << 1) | (bit_at(pos + 2) << 2);
          end else begin
            pos = 32 * half + 8 * row + 2 * (col & 3);
            idx = bit_at(pos) | (bit_at(pos + 1) << 1);
          end
          t.texel_row    = row[1:0];
          t.texel_column = col[2:0];
          t.texel_abgr   = pal[half][idx];
          t.last_texel   = (row == 3 && col == 7);
          owed_texels.push_back(t);
        end
      end
      blocks_noted++;
    endfunction

    function void check_texel(fxt1_out_t got);
      fxt1_out_t want;
      if (owed_texels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected texel %h", got);
        return;
      end
      want = owed_texels.pop_front();
      texels_checked++;
      if (got.texel_row !== want.texel_row || got.texel_column !== want.texel_column ||
          got.texel_abgr !== want.texel_abgr || got.last_texel !== want.last_texel) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("texel mismatch: expected row %0d col %0d abgr %h last %b",
                   want.texel_row, want.texel_column, want.texel_abgr, want.last_texel);
          $display("                got      row %0d col %0d abgr %h last %b",
                   got.texel_row, got.texel_column, got.texel_abgr, got.last_texel);
        end
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;
  localparam int RandomBlocks  = 450;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  fxt1_in_t   in_block;
  logic       out_valid;
  fxt1_out_t  out_texel;

  texel_scoreboard sb;
  int idle_cycles;

  fxt1_block_decoder dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_block(in_block), .out_valid(out_valid), .out_texel(out_texel)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Results are checked at the rising edge that accepts them. The watchdog counts
  // cycles in which neither an item nor a texel is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_texel(out_texel);
      if (out_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired with %0d texels owed", sb.owed_texels.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Presents one block and holds it until the block takes it. Start is driven
  // at the falling edge; acceptance is judged at the rising edge. When the next
  // item follows at once, start simply stays high.
  task automatic send_block(fxt1_in_t blk, bit keep_start);
    @(negedge clk);
    start    <= 1'b1;
    in_block <= blk;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_block(blk);
    if (!keep_start) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Random block. Most blocks aim at one mode with random content; a few are
  // raw noise, which still covers every mode.
  function automatic fxt1_in_t random_block();
    fxt1_in_t b;
    b = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1:    b.block_word3[31]    = 1'b1;
      2, 3:    b.block_word3[31:30] = 2'b00;
      4, 5:    b.block_word3[31:29] = 3'b010;
      6, 7, 8: b.block_word3[31:29] = 3'b011;
      default: ;
    endcase
    return b;
  endfunction

  task automatic idle_gap(int n);
    repeat (n) @(negedge clk);
  endtask

  initial begin
    fxt1_in_t directed[$];
    fxt1_in_t b;
    int burst;
    sb          = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_block    = '0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: each mode and sub-mode with all zeros, all ones and a
    // checker pattern, so that every field sits at both of its extremes.
    for (int m = 0; m < 6; m++) begin
      for (int p = 0; p < 3; p++) begin
        b = (p == 0) ? '0 : (p == 1) ? '1 : {4{32'hA5C3_5A3C}};
        case (m)
          0: b.block_word3[31:28] = {1'b1, b.block_word3[30:29], 1'b0};
          1: b.block_word3[31:28] = {1'b1, b.block_word3[30:29], 1'b1};
          2: b.block_word3[31:30] = 2'b00;
          3: b.block_word3[31:29] = 3'b010;
          4: b.block_word3[31:28] = 4'b0110;
          default: b.block_word3[31:28] = 4'b0111;
        endcase
        directed.push_back(b);
      end
    end
    directed.push_back('1);
    directed.push_back('0);
    foreach (directed[i]) send_block(directed[i], i != directed.size() - 1);

    // Random part: bursts of back-to-back blocks between random gaps, with a
    // few long gaps that let the block run dry.
    for (int n = 0; n < RandomBlocks; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < RandomBlocks; k++, n++)
        send_block(random_block(), k != burst - 1 && n != RandomBlocks - 1);
      if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(40, 120));
      else idle_gap($urandom_range(0, 20));
    end

    while (sb.owed_texels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Decoded %0d blocks over all four modes and sub-modes; %0d texels checked.",
             sb.blocks_noted, sb.texels_checked);
    if (sb.mismatches == 0 && sb.owed_texels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
